// ===== rtl/tccb_pkg.sv =====
// Shared constants, opcodes and controller/datapath interface types for the console buffer.
package tccb_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Fixed port field widths
  localparam int OP_W       = 3;
  localparam int BYTE_W     = 8;
  localparam int IN_COL_W   = 7;
  localparam int IN_ROW_W   = 5;
  localparam int OUT_COL_W  = 7;
  localparam int OUT_ROW_W  = 5;

  localparam logic [OP_W-1:0] OP_PUT_CHAR    = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR       = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_COLOR   = 3'd2;
  localparam logic [OP_W-1:0] OP_PUT_CHAR_AT = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_CURSOR  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_CELL   = 3'd5;

  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [BYTE_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_BS      = 8'h08;

  localparam int TAB_STEP = 8;

  typedef struct packed {
    logic latch;   // capture the incoming item
    logic exec;    // perform the latched operation
    logic fill;    // one step of the space fill sweep
    logic finish;  // load the result registers
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;    // operation needs the registered memory read
    logic need_fill;  // operation leaves a row or the whole grid to fill
    logic fill_last;  // fill sweep is on its last cell
  } dp_status_t;

endpackage

// ===== rtl/text_console_cell_buffer_core.sv =====
// Top level of the text console cell buffer: controller plus datapath.
//
// One command is taken when start is high and busy is low; every command answers
// with one result, shown for a single cycle while out_valid is high, and the
// receiver cannot hold it off. Most commands pass through accept and execute only,
// and the next command can be taken in the cycle the result is shown; an in-grid
// read_cell adds a read wait for the registered read of the cell memory. A command
// that scrolls then fills the new bottom row one cell a cycle (scrolling itself is
// a row offset into a ring of rows), and clear fills the full grid. After reset,
// busy stays high while the grid is filled with spaces.
module text_console_cell_buffer_core #(
  parameter int COLUMNS = tccb_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccb_pkg::DEF_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [tccb_pkg::OP_W-1:0]       in_opcode,
  input  logic [tccb_pkg::BYTE_W-1:0]     in_char_code,
  input  logic [tccb_pkg::BYTE_W-1:0]     in_attribute,
  input  logic [tccb_pkg::IN_COL_W-1:0]   in_column,
  input  logic [tccb_pkg::IN_ROW_W-1:0]   in_row,
  output logic                            out_valid,
  output logic [tccb_pkg::OUT_COL_W-1:0]  out_cursor_column,
  output logic [tccb_pkg::OUT_ROW_W-1:0]  out_cursor_row,
  output logic [tccb_pkg::BYTE_W-1:0]     out_cell_char,
  output logic [tccb_pkg::BYTE_W-1:0]     out_cell_attr,
  output logic                            out_rejected
);

  tccb_pkg::ctrl_cmd_t  cmd;
  tccb_pkg::dp_status_t st;

  tccb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tccb_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_opcode         (in_opcode),
    .in_char_code      (in_char_code),
    .in_attribute      (in_attribute),
    .in_column         (in_column),
    .in_row            (in_row),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .out_cell_char     (out_cell_char),
    .out_cell_attr     (out_cell_attr),
    .out_rejected      (out_rejected)
  );

endmodule

// ===== rtl/tccb_ctrl.sv =====
// Sequencer for the console buffer: accept, execute, read wait and fill sweep.
module tccb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tccb_pkg::dp_status_t st,
  output tccb_pkg::ctrl_cmd_t  cmd,
  output logic                busy,
  output logic                out_valid
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_FILL
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_INIT: begin
        cmd.fill = 1'b1;
        if (st.fill_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.is_read) begin
          state_nxt = S_READ;
        end else if (st.need_fill) begin
          state_nxt = S_FILL;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_READ: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (st.fill_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= cmd.finish;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/tccb_dp.sv =====
// Datapath: cell memory, cursor, scroll offset, fill counters and result registers.
module tccb_dp #(
  parameter int COLUMNS = tccb_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccb_pkg::DEF_ROWS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tccb_pkg::ctrl_cmd_t                 cmd,
  output tccb_pkg::dp_status_t                st,
  input  logic [tccb_pkg::OP_W-1:0]           in_opcode,
  input  logic [tccb_pkg::BYTE_W-1:0]         in_char_code,
  input  logic [tccb_pkg::BYTE_W-1:0]         in_attribute,
  input  logic [tccb_pkg::IN_COL_W-1:0]       in_column,
  input  logic [tccb_pkg::IN_ROW_W-1:0]       in_row,
  output logic [tccb_pkg::OUT_COL_W-1:0]      out_cursor_column,
  output logic [tccb_pkg::OUT_ROW_W-1:0]      out_cursor_row,
  output logic [tccb_pkg::BYTE_W-1:0]         out_cell_char,
  output logic [tccb_pkg::BYTE_W-1:0]         out_cell_attr,
  output logic                                out_rejected
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CW1    = COL_W + 1;
  localparam int RW1    = ROW_W + 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DATA_W = 2 * tccb_pkg::BYTE_W;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int BW     = tccb_pkg::BYTE_W;

  // Physical rows form a ring; top_r is the physical row shown as row 0.
  logic [DATA_W-1:0] cell_mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  logic [COL_W-1:0] cur_col_r,  cur_col_nxt;
  logic [ROW_W-1:0] cur_line_r, cur_line_nxt;
  logic [ROW_W-1:0] top_r,      top_nxt;
  logic [BW-1:0]    attr_r,     attr_nxt;
  logic [COL_W-1:0] fill_col_r, fill_col_nxt;
  logic [ROW_W-1:0] fill_row_r, fill_row_nxt;
  logic             fill_all_r, fill_all_nxt;

  logic [tccb_pkg::OP_W-1:0]     op_r;
  logic [BW-1:0]                 ch_r;
  logic [BW-1:0]                 ain_r;
  logic [tccb_pkg::IN_COL_W-1:0] cin_r;
  logic [tccb_pkg::IN_ROW_W-1:0] rin_r;
  logic                          rej_hold_r;

  logic [tccb_pkg::OUT_COL_W-1:0] out_col_r;
  logic [tccb_pkg::OUT_ROW_W-1:0] out_row_r;
  logic [BW-1:0]                  out_char_r;
  logic [BW-1:0]                  out_attr_r;
  logic                           out_rej_r;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] l,
                                                input logic [ROW_W-1:0] t);
    logic [RW1-1:0] s;
    s = {1'b0, l} + {1'b0, t};
    if (s >= RW1'(ROWS)) s = s - RW1'(ROWS);
    return s[ROW_W-1:0];
  endfunction

  logic             in_grid;
  logic [ROW_W-1:0] in_row_t;
  logic [COL_W-1:0] in_col_t;
  logic [ROW_W-1:0] cur_prow;
  logic [ROW_W-1:0] in_prow;

  assign in_grid  = ({1'b0, cin_r} < (tccb_pkg::IN_COL_W + 1)'(COLUMNS)) &&
                    ({1'b0, rin_r} < (tccb_pkg::IN_ROW_W + 1)'(ROWS));
  assign in_row_t = rin_r[ROW_W-1:0];
  assign in_col_t = cin_r[COL_W-1:0];
  assign cur_prow = phys_row(cur_line_r, top_r);
  assign in_prow  = phys_row(in_row_t, top_r);

  // Operation decode
  logic [COL_W-1:0]  ex_col;
  logic [RW1-1:0]    ex_line;
  logic              ex_we;
  logic [ROW_W-1:0]  ex_wrow;
  logic [COL_W-1:0]  ex_wcol;
  logic [DATA_W-1:0] ex_wdata;
  logic              ex_rej;
  logic              ex_clear;
  logic              ex_scroll;
  logic [CW1-1:0]    col_step;
  logic [CW1-1:0]    tab_col;
  logic [COL_W-1:0]  fin_col;
  logic [ROW_W-1:0]  fin_line;

  assign col_step = {1'b0, cur_col_r} + CW1'(1);
  assign tab_col  = ({1'b0, cur_col_r} + CW1'(tccb_pkg::TAB_STEP)) &
                    ~CW1'(tccb_pkg::TAB_STEP - 1);

  always_comb begin
    ex_col    = cur_col_r;
    ex_line   = {1'b0, cur_line_r};
    ex_we     = 1'b0;
    ex_wrow   = cur_prow;
    ex_wcol   = cur_col_r;
    ex_wdata  = {ch_r, attr_r};
    ex_rej    = 1'b0;
    ex_clear  = 1'b0;
    ex_scroll = 1'b0;
    case (op_r)
      tccb_pkg::OP_PUT_CHAR: begin
        if (ch_r == tccb_pkg::CH_NEWLINE) begin
          ex_col  = '0;
          ex_line = {1'b0, cur_line_r} + RW1'(1);
        end else if (ch_r == tccb_pkg::CH_CR) begin
          ex_col = '0;
        end else if (ch_r == tccb_pkg::CH_TAB) begin
          if (tab_col >= CW1'(COLUMNS)) begin
            ex_col  = '0;
            ex_line = {1'b0, cur_line_r} + RW1'(1);
          end else begin
            ex_col = tab_col[COL_W-1:0];
          end
        end else if (ch_r == tccb_pkg::CH_BS) begin
          if (cur_col_r != '0) begin
            ex_col   = cur_col_r - COL_W'(1);
            ex_we    = 1'b1;
            ex_wcol  = cur_col_r - COL_W'(1);
            ex_wdata = {tccb_pkg::SPACE_CHAR, attr_r};
          end
        end else begin
          ex_we = 1'b1;
          if (col_step >= CW1'(COLUMNS)) begin
            ex_col  = '0;
            ex_line = {1'b0, cur_line_r} + RW1'(1);
          end else begin
            ex_col = col_step[COL_W-1:0];
          end
        end
        if (ex_line >= RW1'(ROWS)) begin
          ex_scroll = 1'b1;
          ex_line   = RW1'(ROWS - 1);
        end
      end
      tccb_pkg::OP_CLEAR: begin
        ex_clear = 1'b1;
        ex_col   = '0;
        ex_line  = '0;
      end
      tccb_pkg::OP_PUT_CHAR_AT: begin
        if (in_grid) begin
          ex_we    = 1'b1;
          ex_wrow  = in_prow;
          ex_wcol  = in_col_t;
          ex_wdata = {ch_r, ain_r};
        end else begin
          ex_rej = 1'b1;
        end
      end
      tccb_pkg::OP_SET_CURSOR: begin
        if (in_grid) begin
          ex_col  = in_col_t;
          ex_line = {1'b0, in_row_t};
        end else begin
          ex_rej = 1'b1;
        end
      end
      tccb_pkg::OP_READ_CELL: begin
        ex_rej = !in_grid;
      end
      default: begin
      end
    endcase
  end

  logic fill_col_end;
  assign fill_col_end = (fill_col_r == COL_W'(COLUMNS - 1));

  always_comb begin
    cur_col_nxt  = cur_col_r;
    cur_line_nxt = cur_line_r;
    top_nxt      = top_r;
    attr_nxt     = attr_r;
    fill_col_nxt = fill_col_r;
    fill_row_nxt = fill_row_r;
    fill_all_nxt = fill_all_r;
    if (cmd.exec) begin
      cur_col_nxt  = ex_col;
      cur_line_nxt = ex_line[ROW_W-1:0];
      if (op_r == tccb_pkg::OP_SET_COLOR) attr_nxt = ain_r;
      if (ex_clear) begin
        top_nxt      = '0;
        fill_col_nxt = '0;
        fill_row_nxt = '0;
        fill_all_nxt = 1'b1;
      end else if (ex_scroll) begin
        // the old top row becomes the new bottom row
        top_nxt      = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + ROW_W'(1);
        fill_col_nxt = '0;
        fill_row_nxt = top_r;
        fill_all_nxt = 1'b0;
      end
    end
    if (cmd.fill) begin
      if (fill_col_end) begin
        fill_col_nxt = '0;
        fill_row_nxt = fill_row_r + ROW_W'(1);
      end else begin
        fill_col_nxt = fill_col_r + COL_W'(1);
      end
    end
  end

  assign fin_col  = cur_col_nxt;
  assign fin_line = cur_line_nxt;

  assign st.is_read   = (op_r == tccb_pkg::OP_READ_CELL) && in_grid;
  assign st.need_fill = ex_clear || ex_scroll;
  assign st.fill_last = fill_col_end &&
                        (!fill_all_r || (fill_row_r == ROW_W'(ROWS - 1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r  <= '0;
      cur_line_r <= '0;
      top_r      <= '0;
      attr_r     <= tccb_pkg::RESET_ATTR;
      fill_col_r <= '0;
      fill_row_r <= '0;
      fill_all_r <= 1'b1;
    end else begin
      cur_col_r  <= cur_col_nxt;
      cur_line_r <= cur_line_nxt;
      top_r      <= top_nxt;
      attr_r     <= attr_nxt;
      fill_col_r <= fill_col_nxt;
      fill_row_r <= fill_row_nxt;
      fill_all_r <= fill_all_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_opcode;
      ch_r  <= in_char_code;
      ain_r <= in_attribute;
      cin_r <= in_column;
      rin_r <= in_row;
    end
    if (cmd.exec) rej_hold_r <= ex_rej;
    if (cmd.finish) begin
      out_col_r <= tccb_pkg::OUT_COL_W'(fin_col);
      out_row_r <= tccb_pkg::OUT_ROW_W'(fin_line);
      out_rej_r <= cmd.exec ? ex_rej : rej_hold_r;
      if (!cmd.exec && st.is_read) begin
        out_char_r <= rd_data_r[DATA_W-1:BW];
        out_attr_r <= rd_data_r[BW-1:0];
      end else begin
        out_char_r <= '0;
        out_attr_r <= '0;
      end
    end
  end

  // Cell memory: one write port, one registered read port
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  always_comb begin
    if (cmd.fill) begin
      mem_we    = 1'b1;
      mem_waddr = {fill_row_r, fill_col_r};
      mem_wdata = {tccb_pkg::SPACE_CHAR, attr_r};
    end else begin
      mem_we    = cmd.exec && ex_we;
      mem_waddr = {ex_wrow, ex_wcol};
      mem_wdata = ex_wdata;
    end
  end

  assign mem_raddr = {in_prow, in_col_t};

  always_ff @(posedge clk) begin
    if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= cell_mem[mem_raddr];
  end

  assign out_cursor_column = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cell_char     = out_char_r;
  assign out_cell_attr     = out_attr_r;
  assign out_rejected      = out_rej_r;

endmodule

// ===== verif/console_grid_checker.sv =====
// Checker for the console cell buffer: mirrors the grid and cursor, compares every reply.
module console_grid_checker #(
  parameter int COLUMNS = tccb_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccb_pkg::DEF_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [tccb_pkg::OP_W-1:0]       in_opcode,
  input  logic [tccb_pkg::BYTE_W-1:0]     in_char_code,
  input  logic [tccb_pkg::BYTE_W-1:0]     in_attribute,
  input  logic [tccb_pkg::IN_COL_W-1:0]   in_column,
  input  logic [tccb_pkg::IN_ROW_W-1:0]   in_row,
  input  logic                            out_valid,
  input  logic [tccb_pkg::OUT_COL_W-1:0]  out_cursor_column,
  input  logic [tccb_pkg::OUT_ROW_W-1:0]  out_cursor_row,
  input  logic [tccb_pkg::BYTE_W-1:0]     out_cell_char,
  input  logic [tccb_pkg::BYTE_W-1:0]     out_cell_attr,
  input  logic                            out_rejected,
  output int                              fail_count,
  output int                              replies_owed
);
  import tccb_pkg::*;

  typedef struct {
    logic [OUT_COL_W-1:0] cur_col;
    logic [OUT_ROW_W-1:0] cur_row;
    logic [BYTE_W-1:0]    cell_char;
    logic [BYTE_W-1:0]    cell_attr;
    logic                 rejected;
  } console_reply_t;

  console_reply_t  pending_replies[$];

  logic [BYTE_W-1:0] glyphs [ROWS][COLUMNS];
  logic [BYTE_W-1:0] colors [ROWS][COLUMNS];
  int                cursor_x;
  int                cursor_y;
  logic [BYTE_W-1:0] pen_attr;

  function automatic void blank_screen();
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLUMNS; c++) begin
        glyphs[r][c] = SPACE_CHAR;
        colors[r][c] = pen_attr;
      end
    end
  endfunction

  function automatic void line_feed();
    cursor_x = 0;
    cursor_y++;
  endfunction

  function automatic void scroll_if_off_bottom();
    if (cursor_y >= ROWS) begin
      for (int r = 0; r < ROWS - 1; r++) begin
        for (int c = 0; c < COLUMNS; c++) begin
          glyphs[r][c] = glyphs[r+1][c];
          colors[r][c] = colors[r+1][c];
        end
      end
      for (int c = 0; c < COLUMNS; c++) begin
        glyphs[ROWS-1][c] = SPACE_CHAR;
        colors[ROWS-1][c] = pen_attr;
      end
      cursor_y = ROWS - 1;
    end
  endfunction

  function automatic void type_char(logic [BYTE_W-1:0] ch);
    if (ch == CH_NEWLINE) begin
      line_feed();
    end else if (ch == CH_CR) begin
      cursor_x = 0;
    end else if (ch == CH_TAB) begin
      cursor_x = (cursor_x + TAB_STEP) & ~(TAB_STEP - 1);
      if (cursor_x >= COLUMNS) line_feed();
    end else if (ch == CH_BS) begin
      // no wrap back to the previous row
      if (cursor_x > 0) begin
        cursor_x--;
        glyphs[cursor_y][cursor_x] = SPACE_CHAR;
        colors[cursor_y][cursor_x] = pen_attr;
      end
    end else begin
      glyphs[cursor_y][cursor_x] = ch;
      colors[cursor_y][cursor_x] = pen_attr;
      cursor_x++;
      if (cursor_x >= COLUMNS) line_feed();
    end
    scroll_if_off_bottom();
  endfunction

  function automatic console_reply_t apply_console_op(
    logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] attr,
    logic [IN_COL_W-1:0] col, logic [IN_ROW_W-1:0] row);
    console_reply_t rep;
    logic           on_grid;
    on_grid = (int'(col) < COLUMNS) && (int'(row) < ROWS);
    rep.cell_char = '0;
    rep.cell_attr = '0;
    rep.rejected  = 1'b0;
    case (op)
      OP_PUT_CHAR: type_char(ch);
      OP_CLEAR: begin
        blank_screen();
        cursor_x = 0;
        cursor_y = 0;
      end
      OP_SET_COLOR: pen_attr = attr;
      OP_PUT_CHAR_AT: begin
        if (on_grid) begin
          glyphs[row][col] = ch;
          colors[row][col] = attr;
        end else begin
          rep.rejected = 1'b1;
        end
      end
      OP_SET_CURSOR: begin
        if (on_grid) begin
          cursor_x = int'(col);
          cursor_y = int'(row);
        end else begin
          rep.rejected = 1'b1;
        end
      end
      OP_READ_CELL: begin
        if (on_grid) begin
          rep.cell_char = glyphs[row][col];
          rep.cell_attr = colors[row][col];
        end else begin
          rep.rejected = 1'b1;
        end
      end
      default: ;
    endcase
    rep.cur_col = cursor_x[OUT_COL_W-1:0];
    rep.cur_row = cursor_y[OUT_ROW_W-1:0];
    return rep;
  endfunction

  function automatic bit field_differs(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    console_reply_t want;
    bit             bad;
    if (!rst_n) begin
      pen_attr = RESET_ATTR;
      blank_screen();
      cursor_x = 0;
      cursor_y = 0;
      pending_replies.delete();
    end else begin
      // compare before queuing: a reply never belongs to the item taken at the same edge
      if (out_valid) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected reply, expected none, actual col %0d row %0d",
                   $time, out_cursor_column, out_cursor_row);
          fail_count++;
        end else begin
          want = pending_replies.pop_front();
          bad  = 1'b0;
          bad |= field_differs("cursor_column", int'(want.cur_col),
                               int'(out_cursor_column));
          bad |= field_differs("cursor_row", int'(want.cur_row), int'(out_cursor_row));
          bad |= field_differs("cell_char", int'(want.cell_char), int'(out_cell_char));
          bad |= field_differs("cell_attr", int'(want.cell_attr), int'(out_cell_attr));
          bad |= field_differs("rejected", int'(want.rejected), int'(out_rejected));
          if (bad) fail_count++;
        end
      end
      if (start && !busy)
        pending_replies.push_back(apply_console_op(in_opcode, in_char_code, in_attribute,
                                                   in_column, in_row));
    end
    replies_owed <= pending_replies.size();
  end

endmodule

// ===== verif/tb_text_console_cell_buffer_core.sv =====
// Testbench top for the console cell buffer: clock, reset, command stimulus and verdict.
module tb_text_console_cell_buffer_core;
  import tccb_pkg::*;

  localparam int COLUMNS        = DEF_COLUMNS;
  localparam int ROWS           = DEF_ROWS;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int WATCHDOG_LIMIT = 12000;

  // opcodes the block has no use for; they must still answer
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic [IN_COL_W-1:0] COL_LAST = IN_COL_W'(COLUMNS - 1);
  localparam logic [IN_ROW_W-1:0] ROW_LAST = IN_ROW_W'(ROWS - 1);

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 start        = 1'b0;
  logic [OP_W-1:0]      in_opcode    = '0;
  logic [BYTE_W-1:0]    in_char_code = '0;
  logic [BYTE_W-1:0]    in_attribute = '0;
  logic [IN_COL_W-1:0]  in_column    = '0;
  logic [IN_ROW_W-1:0]  in_row       = '0;
  logic                 busy;
  logic                 out_valid;
  logic [OUT_COL_W-1:0] out_cursor_column;
  logic [OUT_ROW_W-1:0] out_cursor_row;
  logic [BYTE_W-1:0]    out_cell_char;
  logic [BYTE_W-1:0]    out_cell_attr;
  logic                 out_rejected;
  int                   fail_count;
  int                   replies_owed;
  int                   idle_cycles = 0;
  bit                   no_gaps = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  text_console_cell_buffer_core #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_char_code(in_char_code), .in_attribute(in_attribute),
    .in_column(in_column), .in_row(in_row),
    .out_valid(out_valid), .out_cursor_column(out_cursor_column),
    .out_cursor_row(out_cursor_row), .out_cell_char(out_cell_char),
    .out_cell_attr(out_cell_attr), .out_rejected(out_rejected)
  );

  console_grid_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_char_code(in_char_code), .in_attribute(in_attribute),
    .in_column(in_column), .in_row(in_row),
    .out_valid(out_valid), .out_cursor_column(out_cursor_column),
    .out_cursor_row(out_cursor_row), .out_cell_char(out_cell_char),
    .out_cell_attr(out_cell_attr), .out_rejected(out_rejected),
    .fail_count(fail_count), .replies_owed(replies_owed)
  );

  // cycles with neither an item taken nor a reply shown
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("text_console_cell_buffer_core regression: fail");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // called at a clock edge; returns at the edge where the item is taken
  task automatic issue_command(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch,
                               logic [BYTE_W-1:0] attr, logic [IN_COL_W-1:0] col,
                               logic [IN_ROW_W-1:0] row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_opcode    <= op;
    in_char_code <= ch;
    in_attribute <= attr;
    in_column    <= col;
    in_row       <= row;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [BYTE_W-1:0] pick_char();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return BYTE_W'($urandom_range(8'h21, 8'h7E));
    if (p < 67) return CH_NEWLINE;
    if (p < 72) return CH_CR;
    if (p < 78) return CH_TAB;
    if (p < 85) return CH_BS;
    return rand_byte();
  endfunction

  task automatic pick_position(output logic [IN_COL_W-1:0] col,
                               output logic [IN_ROW_W-1:0] row);
    int p;
    p = $urandom_range(0, 99);
    if (p < 15) begin
      col = IN_COL_W'($urandom_range(0, 127));
      row = IN_ROW_W'($urandom_range(0, 31));
    end else if (p < 25) begin
      col = $urandom_range(0, 1) ? COL_LAST : '0;
      row = $urandom_range(0, 1) ? ROW_LAST : '0;
    end else begin
      col = IN_COL_W'($urandom_range(0, COLUMNS - 1));
      row = IN_ROW_W'($urandom_range(0, ROWS - 1));
    end
  endtask

  task automatic run_directed();
    issue_command(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0);
    issue_command(OP_READ_CELL, 8'hFF, 8'hFF, COL_LAST, ROW_LAST);
    issue_command(OP_READ_CELL, 8'h00, 8'h00, IN_COL_W'(COLUMNS), 5'd0);
    issue_command(OP_READ_CELL, 8'h00, 8'h00, 7'd127, 5'd31);
    issue_command(OP_READ_CELL, 8'h00, 8'h00, 7'd0, IN_ROW_W'(ROWS));
    issue_command(OP_PUT_CHAR, 8'h41, 8'h00, 7'd0, 5'd0);
    issue_command(OP_PUT_CHAR, CH_BS, 8'h00, 7'd0, 5'd0);
    issue_command(OP_PUT_CHAR, CH_BS, 8'h00, 7'd0, 5'd0);   // backspace at column 0
    issue_command(OP_PUT_CHAR, CH_TAB, 8'h00, 7'd0, 5'd0);
    issue_command(OP_PUT_CHAR, CH_CR, 8'h00, 7'd0, 5'd0);
    issue_command(OP_PUT_CHAR, CH_NEWLINE, 8'h00, 7'd0, 5'd0);
    issue_command(OP_SET_COLOR, 8'h00, 8'hFF, 7'd0, 5'd0);
    issue_command(OP_PUT_CHAR, 8'hFF, 8'h00, 7'd0, 5'd0);
    issue_command(OP_PUT_CHAR_AT, 8'h00, 8'h00, COL_LAST, ROW_LAST);
    issue_command(OP_PUT_CHAR_AT, 8'h55, 8'h55, IN_COL_W'(COLUMNS), 5'd31);
    issue_command(OP_SET_CURSOR, 8'h00, 8'h00, COL_LAST, ROW_LAST);
    issue_command(OP_PUT_CHAR, 8'h7E, 8'h00, 7'd0, 5'd0);   // wraps off the last row
    issue_command(OP_READ_CELL, 8'h00, 8'h00, COL_LAST, IN_ROW_W'(ROWS - 2));
    issue_command(OP_SET_CURSOR, 8'h00, 8'h00, IN_COL_W'(COLUMNS - 8), ROW_LAST);
    issue_command(OP_PUT_CHAR, CH_TAB, 8'h00, 7'd0, 5'd0);  // tab past the right edge
    issue_command(OP_PUT_CHAR, CH_NEWLINE, 8'h00, 7'd0, 5'd0);
    issue_command(OP_SET_CURSOR, 8'h00, 8'h00, 7'd127, 5'd0);
    issue_command(OP_SPARE_6, 8'hFF, 8'hFF, 7'd127, 5'd31);
    issue_command(OP_SPARE_7, 8'h00, 8'h00, 7'd0, 5'd0);
    issue_command(OP_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0);
    issue_command(OP_READ_CELL, 8'h00, 8'h00, IN_COL_W'(COLUMNS / 2), IN_ROW_W'(ROWS / 2));
  endtask

  task automatic run_random_traffic();
    int                  sel;
    logic [IN_COL_W-1:0] col;
    logic [IN_ROW_W-1:0] row;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      pick_position(col, row);
      if (sel < 55 || (sel >= 94 && sel < 99)) begin
        issue_command(OP_PUT_CHAR, pick_char(), rand_byte(), col, row);
      end else if (sel < 65) begin
        issue_command(OP_READ_CELL, rand_byte(), rand_byte(), col, row);
      end else if (sel < 73) begin
        issue_command(OP_PUT_CHAR_AT, rand_byte(), rand_byte(), col, row);
      end else if (sel < 83) begin
        // lean toward the bottom row so that typing scrolls often
        if ($urandom_range(0, 2) == 0) row = ROW_LAST;
        issue_command(OP_SET_CURSOR, rand_byte(), rand_byte(), col, row);
      end else if (sel < 91) begin
        issue_command(OP_SET_COLOR, rand_byte(), rand_byte(), col, row);
      end else if (sel < 94) begin
        issue_command($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7,
                      rand_byte(), rand_byte(), col, row);
      end else begin
        issue_command(OP_CLEAR, rand_byte(), rand_byte(), col, row);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random_traffic();
    start <= 1'b0;
    // let the count include the last item taken
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0)
      $display("text_console_cell_buffer_core regression: pass");
    else
      $display("text_console_cell_buffer_core regression: fail");
    $finish;
  end

endmodule
